### src/fpa_pkg.sv
// Package for the fixed-point ALU: opcode type.
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_GT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

endpackage

### src/fpa_div_cell.sv
// One restoring-division cell: retires one quotient bit per pipeline stage.
module fpa_div_cell #(
    parameter int DW = 40,
    parameter int RW = 41,
    parameter int PW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ready_in,
    input  logic          valid_in,
    input  logic [DW-1:0] num_in,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [PW-1:0] pass_in,
    output logic          valid_out,
    output logic [DW-1:0] num_out,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] den_out,
    output logic [PW-1:0] pass_out
);
    logic          valid_reg;
    logic [DW-1:0] num_reg, rem_reg, den_reg;
    logic [PW-1:0] pass_reg;
    logic [RW-1:0] trial;
    logic [RW-1:0] diff;
    logic [DW-1:0] rem_next, num_next;

    always_comb begin
        trial    = {rem_in, num_in[DW-1]};
        diff     = trial - {1'b0, den_in};
        num_next = {num_in[DW-2:0], ~diff[RW-1]};
        rem_next = diff[RW-1] ? trial[DW-1:0] : diff[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_in) begin
            valid_reg <= valid_in;
        end
        if (ready_in) begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign num_out   = num_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign pass_out  = pass_reg;
endmodule

### src/fixed_point_alu.sv
// Top level of the fixed-point ALU: operand stage, divider cell chain, result stage.
// Signed fixed-point ALU, WORD_BITS wide with FRACTION_BITS fraction bits.
// Input channel s_axis_*: tdata = {operand_b, operand_a, op}, one operation per transfer.
// Result channel m_axis_*: tdata = {divide_by_zero, compare_true, value}, one result
// per input transfer, in order.
// Every operation travels through the same pipeline: an operand stage that takes
// magnitudes and forms the multiply product, a chain of WORD_BITS+FRACTION_BITS
// division cells (one quotient bit each), and a result register. Throughput is one
// transfer per cycle while the result channel is not stalled, set by the
// one-bit-per-cell divider chain.
// The whole pipeline advances together whenever the result register is empty or
// taken; a stalled receiver freezes every stage and drops s_axis_tready, so no
// transfer is lost. Synchronous reset (aresetn low) clears all valid bits.
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8,
    parameter int WORD_BITS     = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op[3:0], operand_a, operand_b, zero fill
    input  logic [((2*WORD_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // value, compare_true, divide_by_zero, zero fill
    output logic [((WORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
    import fpa_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int DW  = W + F;
    localparam int NC  = DW;
    localparam int IW  = ((2*W+4+7)/8)*8;
    localparam int OW  = ((W+2+7)/8)*8;
    // pass: op(4) neg(1) dz(1) cmp(1) val(W)
    localparam int PW  = W + 7;

    logic advance;
    logic m_valid_reg;
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    op_t          in_op;
    logic [W-1:0] a, b, mag_a, mag_b;
    logic         neg, a_lt_b, b_lt_a;
    logic [W-1:0] val_c;
    logic         cmp_c;

    assign in_op = op_t'(s_axis_tdata[3:0]);
    assign a     = s_axis_tdata[W+3:4];
    assign b     = s_axis_tdata[2*W+3:W+4];
    assign neg   = a[W-1] ^ b[W-1];
    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;
    assign a_lt_b = $signed(a) < $signed(b);
    assign b_lt_a = $signed(b) < $signed(a);

    // Combinational results for everything but multiply and divide.
    always_comb begin
        val_c = '0;
        cmp_c = 1'b0;
        case (in_op)
            OP_ADD:      val_c = a + b;
            OP_SUB:      val_c = a - b;
            OP_LT:       cmp_c = a_lt_b;
            OP_GT:       cmp_c = b_lt_a;
            OP_LE:       cmp_c = !b_lt_a;
            OP_GE:       cmp_c = !a_lt_b;
            OP_EQ:       cmp_c = (a == b);
            OP_NE:       cmp_c = (a != b);
            OP_MIN:      val_c = a_lt_b ? a : b;
            OP_MAX:      val_c = b_lt_a ? a : b;
            OP_INC:      val_c = a + 1'b1;
            OP_DEC:      val_c = a - 1'b1;
            OP_FROM_INT: val_c = a << F;
            OP_TO_INT:   val_c = W'($signed(a) >>> F);
            default:     val_c = '0;
        endcase
    end

    // Operand stage: register magnitudes, multiply in the next stage.
    logic         s0_valid_reg;
    logic [W-1:0] s0_ma_reg, s0_mb_reg;
    logic [PW-1:0] s0_pass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (advance) begin
            s0_valid_reg <= s_axis_tvalid;
        end
        if (advance) begin
            s0_ma_reg   <= mag_a;
            s0_mb_reg   <= mag_b;
            s0_pass_reg <= {in_op, neg, (in_op == OP_DIV) && (b == '0), cmp_c, val_c};
        end
    end

    // Product of magnitudes, truncated by F; low W bits kept in pass value.
    logic [2*W-1:0] prod;
    logic [W-1:0]   prod_sh;
    logic [PW-1:0]  c_pass;
    op_t            s0_op;
    assign prod    = s0_ma_reg * s0_mb_reg;
    assign prod_sh = prod[F+W-1:F];
    assign s0_op   = op_t'(s0_pass_reg[PW-1:PW-4]);
    assign c_pass  = (s0_op == OP_MUL) ? {s0_pass_reg[PW-1:W], prod_sh} : s0_pass_reg;

    // Divider cell chain.
    logic          cv   [NC+1];
    logic [DW-1:0] cn   [NC+1];
    logic [DW-1:0] cr   [NC+1];
    logic [DW-1:0] cd   [NC+1];
    logic [PW-1:0] cp   [NC+1];

    assign cv[0] = s0_valid_reg;
    assign cn[0] = {s0_ma_reg, F'(0)};
    assign cr[0] = '0;
    assign cd[0] = {F'(0), s0_mb_reg};
    assign cp[0] = c_pass;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        fpa_div_cell #(.DW(DW), .RW(DW+1), .PW(PW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ready_in(advance),
            .valid_in(cv[i]), .num_in(cn[i]), .rem_in(cr[i]),
            .den_in(cd[i]), .pass_in(cp[i]),
            .valid_out(cv[i+1]), .num_out(cn[i+1]), .rem_out(cr[i+1]),
            .den_out(cd[i+1]), .pass_out(cp[i+1])
        );
    end

    // Result stage.
    logic [PW-1:0] lp;
    logic [W-1:0]  q, mag_r, val_f;
    logic          l_neg, l_dz;
    op_t           l_op;
    assign lp    = cp[NC];
    assign l_op  = op_t'(lp[PW-1:PW-4]);
    assign l_neg = lp[PW-5];
    assign l_dz  = lp[PW-6];
    assign q     = cn[NC][W-1:0];

    always_comb begin
        mag_r = (l_op == OP_DIV) ? q : lp[W-1:0];
        val_f = lp[W-1:0];
        if (l_op == OP_MUL || l_op == OP_DIV) begin
            val_f = l_neg ? (~mag_r + 1'b1) : mag_r;
        end
        if (l_dz) begin
            val_f = '0;
        end
    end

    logic [W+1:0] m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= cv[NC];
        end
        if (advance) begin
            m_data_reg <= {l_dz, lp[W], val_f};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(OW-W-2)'(0), m_data_reg};

    logic unused_in;
    assign unused_in = ^s_axis_tdata[IW-1:2*W+4] ^ ^prod[2*W-1:F+W] ^ ^prod[F-1:0]
                       ^ ^cr[NC] ^ ^cd[NC] ^ ^cn[NC][DW-1:W];
endmodule

### verif/testbench.sv
// Testbench for the fixed-point ALU: random and directed operations checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import fpa_pkg::*;

    localparam int FB = 8;
    localparam int WB = 32;
    localparam int S_BITS = ((2*WB+4+7)/8)*8;
    localparam int M_BITS = ((WB+2+7)/8)*8;
    localparam int LATENCY = WB + FB + 2;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 630;

    typedef struct packed {
        logic        dz;
        logic        cmp;
        logic [31:0] value;
    } alu_result_t;

    // Expected results, oldest first, and the comparison of each result.
    class alu_scoreboard;
        alu_result_t pending[$];
        int errors;
        int checked;

        function new();
            errors = 0;
            checked = 0;
        endfunction

        // Work out the result of one operation at full width.
        function alu_result_t compute(op_t op, logic signed [31:0] a, logic signed [31:0] b);
            alu_result_t r;
            logic signed [63:0] wide;
            logic signed [63:0] dividend;
            r = '0;
            case (op)
                OP_ADD: r.value = a + b;
                OP_SUB: r.value = a - b;
                OP_MUL: begin
                    wide = 64'(a) * 64'(b);
                    // signed division truncates toward zero
                    wide = wide / 64'sd256;
                    r.value = wide[31:0];
                end
                OP_DIV: begin
                    if (b == 0) begin
                        r.dz = 1'b1;
                    end else begin
                        dividend = 64'(a) <<< FB;
                        wide = dividend / 64'(b);
                        r.value = wide[31:0];
                    end
                end
                OP_LT: r.cmp = a < b;
                OP_GT: r.cmp = a > b;
                OP_LE: r.cmp = a <= b;
                OP_GE: r.cmp = a >= b;
                OP_EQ: r.cmp = a == b;
                OP_NE: r.cmp = a != b;
                OP_MIN: r.value = (a < b) ? a : b;
                OP_MAX: r.value = (b < a) ? a : b;
                OP_INC: r.value = a + 1;
                OP_DEC: r.value = a - 1;
                OP_FROM_INT: r.value = a << FB;
                default: r.value = a >>> FB;
            endcase
            return r;
        endfunction

        function void note_input(logic [S_BITS-1:0] data);
            pending.push_back(compute(op_t'(data[3:0]), data[35:4], data[67:36]));
        endfunction

        function void check_result(logic [M_BITS-1:0] data);
            alu_result_t got;
            alu_result_t want;
            got = data[33:0];
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                errors++;
            end
            if (got.cmp !== want.cmp) begin
                $display("%0t: compare flag expected %b actual %b", $time, want.cmp, got.cmp);
                errors++;
            end
            if (got.dz !== want.dz) begin
                $display("%0t: div-zero flag expected %b actual %b", $time, want.dz, got.dz);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // op[3:0], operand_a[35:4], operand_b[67:36], zero fill
    logic [S_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // value[31:0], compare_true[32], divide_by_zero[33], zero fill
    logic [M_BITS-1:0] m_axis_tdata;

    alu_scoreboard board = new();
    int sent = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;   // sender asks the receiver for a long hold-off

    always #5 aclk = ~aclk;

    fixed_point_alu #(.FRACTION_BITS(FB), .WORD_BITS(WB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Note transfers on both channels at the edge where they complete.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                board.note_input(s_axis_tdata);
                sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still expected",
                     $time, board.pending.size());
            $display("status: fail");
            $finish;
        end
    end

    // Pick a gap length: mostly zero or short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Receiver: drive tready with random stalls; honor a long hold-off on request.
    initial begin : receiver
        int gap;
        int burst;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (3 * LATENCY) @(posedge aclk);
                long_hold = 1'b0;
            end
            burst = $urandom_range(30, 1);
            m_axis_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            gap = gap_length();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Offer one operation and hold it until it transfers.
    task automatic send_op(op_t op, logic [31:0] a, logic [31:0] b, bit allow_gap);
        int gap;
        s_axis_tdata <= {{(S_BITS-68){1'b0}}, b, a, op};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    // Random operand with a bias toward edge values and small magnitudes.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(3) - 1;
            3, 4: return $signed($urandom_range(4095)) - 2048;
            5: return $signed($urandom_range(1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] edges [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                   32'hffff_ffff, 32'h1, 32'h100};
        logic [31:0] a;
        logic [31:0] b;
        op_t op;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every opcode on edge operands, equal operands, divide by zero.
        for (int k = 0; k < 16; k++)
            send_op(op_t'(k), edges[k % 6], edges[(k + 3) % 6], 1'b0);
        send_op(OP_DIV, 32'h0000_0500, 32'h0, 1'b0);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0);
        send_op(OP_DIV, 32'hffff_ff01, 32'h0000_0300, 1'b0);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_op(OP_MIN, 32'h0000_1234, 32'h0000_1234, 1'b0);
        send_op(OP_MAX, 32'hffff_fe00, 32'hffff_fe00, 1'b0);
        send_op(OP_TO_INT, 32'hffff_ff01, 32'h0, 1'b0);
        send_op(OP_INC, 32'h7fff_ffff, 32'h0, 1'b0);

        // Pause the sender until the pipeline is empty.
        drain();

        // Fill the pipeline against a long receiver hold-off.
        long_hold = 1'b1;
        for (int k = 0; k < 2 * LATENCY; k++)
            send_op(op_t'($urandom_range(15)), pick_operand(), pick_operand(), 1'b0);

        // Random operations, with stretches of back-to-back transfers.
        for (int k = 0; k < RANDOM_ITEMS - 2 * LATENCY; k++) begin
            op = op_t'($urandom_range(15));
            a = pick_operand();
            b = ($urandom_range(7) == 0) ? a : pick_operand();
            send_op(op, a, b, (k / 60) % 3 != 1);
        end

        drain();
        repeat (LATENCY + 4) @(posedge aclk);
        $display("covered %0d operations over all 16 opcodes, %0d results checked",
                 sent, board.checked);
        $display("including edge operands, divide by zero and a full pipeline stall");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### fixed_point_alu.f
src/fpa_pkg.sv
src/fpa_div_cell.sv
src/fixed_point_alu.sv
verif/testbench.sv
